[rtl/core/spk_pkg.sv]
// Shared types and constants for the Speck128/128 encryption pipeline.
`default_nettype none
package spk_pkg;

	localparam int unsigned WORD_W = 64;
	// Round index width; covers round counts up to 64.
	localparam int unsigned RIDX_W = 6;
	localparam int unsigned ROT_R  = 8;
	localparam int unsigned ROT_L  = 3;
	localparam int unsigned ADDR_W = 4;

	// Register index as taken from paddr[3].
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] k0;
		logic [WORD_W-1:0] k1;
	} key_t;

	// Everything one block carries down the chain.
	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		key_t              key;
	} blk_t;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v);
		rotr = {v[ROT_R-1:0], v[WORD_W-1:ROT_R]};
	endfunction

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v);
		rotl = {v[WORD_W-ROT_L-1:0], v[WORD_W-1:WORD_W-ROT_L]};
	endfunction

endpackage
`default_nettype wire

[rtl/core/spk_key_regs.sv]
// APB key register file: two 64-bit key words.
`default_nettype none
module spk_key_regs
	import spk_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output logic      [WORD_W-1:0] prdata,
	output logic                   pready,
	output key_t                   key
);

	logic [WORD_W-1:0] key_low_q;
	logic [WORD_W-1:0] key_high_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Low address bits are byte offsets inside a 64-bit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (wr_en) begin
			case (paddr[3])
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end

	assign key.k0 = key_low_q;
	assign key.k1 = key_high_q;

endmodule
`default_nettype wire

[rtl/core/spk_round_cell.sv]
// One Speck round cell: data round and key schedule round, registered, elastic.
`default_nettype none
module spk_round_cell
	import spk_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [RIDX_W-1:0] round_idx,
	input  wire logic              up_valid,
	output logic                   up_ready,
	input  wire blk_t              up_blk,
	output logic                   dn_valid,
	input  wire logic              dn_ready,
	output blk_t                   dn_blk
);

	logic valid_q;
	blk_t blk_q;
	blk_t nxt;

	always_comb begin
		nxt.y      = (rotr(up_blk.y) + up_blk.x) ^ up_blk.key.k0;
		nxt.x      = rotl(up_blk.x) ^ nxt.y;
		nxt.key.k1 = (rotr(up_blk.key.k1) + up_blk.key.k0)
			^ {{(WORD_W-RIDX_W){1'b0}}, round_idx};
		nxt.key.k0 = rotl(up_blk.key.k0) ^ nxt.key.k1;
	end

	// Hold only while full and the neighbor downstream is stalled.
	assign up_ready = ~valid_q | dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			blk_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_blk   = blk_q;

endmodule
`default_nettype wire

[rtl/core/speck128_128_block_encrypt.sv]
// Speck128/128 encryption: a chain of ROUND_COUNT round cells.
// Each cell registers its round; each holds one block and passes it on.
// Throughput: one block per cycle while out_stall is low.
// The last cell is the output register; bubbles are taken up while it stalls.
// Reset clears all cell valid bits and both key registers to zero.
`default_nettype none
module speck128_128_block_encrypt
	import spk_pkg::*;
#(
	parameter int unsigned ROUND_COUNT = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [WORD_W-1:0] pwdata,
	output logic      [WORD_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [WORD_W-1:0] plain_x,
	input  wire logic [WORD_W-1:0] plain_y,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [WORD_W-1:0] cipher_x,
	output logic      [WORD_W-1:0] cipher_y
);

	key_t key;
	logic valid_c [ROUND_COUNT+1];
	logic ready_c [ROUND_COUNT+1];
	blk_t blk_c   [ROUND_COUNT+1];

	spk_key_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	assign valid_c[0]   = in_valid;
	assign blk_c[0].x   = plain_x;
	assign blk_c[0].y   = plain_y;
	assign blk_c[0].key = key;
	assign in_stall     = ~ready_c[0];

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_cell
		spk_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.round_idx (RIDX_W'(i)),
			.up_valid  (valid_c[i]),
			.up_ready  (ready_c[i]),
			.up_blk    (blk_c[i]),
			.dn_valid  (valid_c[i+1]),
			.dn_ready  (ready_c[i+1]),
			.dn_blk    (blk_c[i+1])
		);
	end

	assign ready_c[ROUND_COUNT] = ~out_stall;
	assign out_valid            = valid_c[ROUND_COUNT];
	assign cipher_x             = blk_c[ROUND_COUNT].x;
	assign cipher_y             = blk_c[ROUND_COUNT].y;

endmodule
`default_nettype wire

[rtl/core/spk_checker.sv]
// Port-level checks for the Speck128/128 encryption block, with bind.
`default_nettype none
module spk_checker
	import spk_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              psel,
	input wire logic              penable,
	input wire logic              pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [WORD_W-1:0] pwdata,
	input wire logic [WORD_W-1:0] prdata,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [WORD_W-1:0] cipher_x,
	input wire logic [WORD_W-1:0] cipher_y
);

	// Input can only back up once the whole chain is full and the output stalls.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output not held");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(cipher_x) && $stable(cipher_y)))
		else $error("stalled result changed");

	// Low key word written at one cycle reads back at the next.
	a_key_rdback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && paddr[3] == REG_KEY_LOW)
		##1 (psel && !pwrite && paddr[3] == REG_KEY_LOW)
		|-> (prdata == $past(pwdata)))
		else $error("key register read back mismatch");

	// Chain is empty by the edge after reset has been seen.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result shown during reset");

endmodule

bind speck128_128_block_encrypt spk_checker u_spk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.cipher_x  (cipher_x),
	.cipher_y  (cipher_y)
);
`default_nettype wire

[dv/speck128_128_block_encrypt_test.sv]
// Testbench for the Speck128/128 encryption pipeline: APB key setup, block traffic, scoreboard.
`default_nettype none
module speck128_128_block_encrypt_test;
	import spk_pkg::*;

	localparam int ROUNDS      = 32;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} word_pair_t;

	class cipher_scoreboard;
		logic [WORD_W-1:0] key_low;
		logic [WORD_W-1:0] key_high;
		word_pair_t        expected_ciphers[$];
		int                mismatches;

		function new();
			key_low    = '0;
			key_high   = '0;
			mismatches = 0;
		endfunction

		function void load_key(logic idx, logic [WORD_W-1:0] value);
			if (idx == REG_KEY_LOW) begin
				key_low = value;
			end else begin
				key_high = value;
			end
		endfunction

		// Key schedule runs alongside the data rounds.
		function word_pair_t encrypt(logic [WORD_W-1:0] px, logic [WORD_W-1:0] py);
			logic [WORD_W-1:0] x, y, k0, k1;
			word_pair_t res;
			x  = px;
			y  = py;
			k0 = key_low;
			k1 = key_high;
			for (int r = 0; r < ROUNDS; r++) begin
				y  = ((y >> ROT_R) | (y << (WORD_W - ROT_R))) + x;
				y  = y ^ k0;
				x  = ((x << ROT_L) | (x >> (WORD_W - ROT_L))) ^ y;
				k1 = ((k1 >> ROT_R) | (k1 << (WORD_W - ROT_R))) + k0;
				k1 = k1 ^ WORD_W'(r);
				k0 = ((k0 << ROT_L) | (k0 >> (WORD_W - ROT_L))) ^ k1;
			end
			res.x = x;
			res.y = y;
			return res;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		function void note_plain(logic [WORD_W-1:0] px, logic [WORD_W-1:0] py);
			expected_ciphers.push_back(encrypt(px, py));
		endfunction

		task check_cipher(logic [WORD_W-1:0] cx, logic [WORD_W-1:0] cy);
			word_pair_t exp_c;
			if (expected_ciphers.size() == 0) begin
				report($sformatf("unexpected result x=%h y=%h", cx, cy));
			end else begin
				exp_c = expected_ciphers.pop_front();
				if (cx !== exp_c.x)
					report($sformatf("cipher_x got %h exp %h", cx, exp_c.x));
				if (cy !== exp_c.y)
					report($sformatf("cipher_y got %h exp %h", cy, exp_c.y));
			end
		endtask
	endclass

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [ADDR_W-1:0] paddr   = '0;
	logic [WORD_W-1:0] pwdata  = '0;
	logic [WORD_W-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [WORD_W-1:0] plain_x   = '0;
	logic [WORD_W-1:0] plain_y   = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] cipher_x;
	logic [WORD_W-1:0] cipher_y;

	int   tx_idle_pct   = 0;
	int   rx_stall_pct  = 0;
	logic hold_req      = 1'b0;
	logic hold_taken    = 1'b0;
	int   hold_left     = 0;
	int   quiet_cycles  = 0;

	cipher_scoreboard sb;

	speck128_128_block_encrypt #(.ROUND_COUNT(ROUNDS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.plain_x   (plain_x),
		.plain_y   (plain_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cipher_x  (cipher_x),
		.cipher_y  (cipher_y)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Monitor: inputs and outputs are stable at the rising edge.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_plain(plain_x, plain_y);
		if (out_valid && !out_stall)
			sb.check_cipher(cipher_x, cipher_y);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off when requested.
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_left  = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Called at a falling edge; returns at a falling edge.
	task automatic send_block(logic [WORD_W-1:0] x, logic [WORD_W-1:0] y);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		plain_x  <= x;
		plain_y  <= y;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		repeat (count) send_block(pick_word(), pick_word());
	endtask

	// Write then read back one key register.
	task automatic write_key_reg(logic idx, logic [WORD_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.load_key(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== value)
			sb.report($sformatf("key reg %0d read %h exp %h", idx, prdata, value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.expected_ciphers.size() != 0) @(negedge clk);
	endtask

	task automatic load_key(logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi);
		in_valid <= 1'b0;
		wait_drained();
		@(negedge clk);
		write_key_reg(REG_KEY_LOW, lo);
		@(negedge clk);
		write_key_reg(REG_KEY_HIGH, hi);
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Key left at its reset value of zero.
		send_block('0, '0);
		send_block('1, '1);
		send_block('0, '1);
		send_block('1, '0);
		send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
		send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
		send_block(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);

		load_key('1, '1);
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h0000_0000_0000_00ff, 64'hff00_0000_0000_0000);

		load_key('0, '1);
		send_block('0, '0);
		send_block('1, '0);

		load_key('1, '0);
		send_block('0, '1);
		send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);

		// Published test vector key and plaintext.
		load_key(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908);
		send_block(64'h6c61_7669_7571_6520, 64'h7469_2065_6461_6d20);
		send_random(90);

		load_key({$urandom, $urandom}, {$urandom, $urandom});
		tx_idle_pct = 70;
		send_random(110);

		load_key({$urandom, $urandom}, {$urandom, $urandom});
		tx_idle_pct = 0;
		rx_stall_pct <= 70;
		send_random(110);

		load_key('0, '0);
		tx_idle_pct = 16;
		rx_stall_pct <= 16;
		send_random(110);

		// Long receiver hold-off with the sender pushing every cycle.
		load_key({$urandom, $urandom}, {$urandom, $urandom});
		tx_idle_pct = 0;
		rx_stall_pct <= 0;
		hold_req <= 1'b1;
		send_random(150);

		in_valid <= 1'b0;
		wait_drained();
		repeat (ROUNDS + 8) @(negedge clk);
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
